/* rtl/core/reee_pkg.sv */
// Package for the resampler energy envelope unit.
// Shared constants and the front-to-back command type. No dependencies.
package reee_pkg;

  localparam int unsigned StepW  = 23;
  localparam int unsigned AlphaW = 16;
  localparam int unsigned HopW   = 13;
  localparam int unsigned SmpW   = 16;
  localparam int unsigned PosW   = 32;
  localparam int unsigned LvlW   = 24;
  localparam int unsigned SumW   = 64;
  localparam int unsigned EnW    = 15;

  localparam logic [1:0] RegStep  = 2'd0;
  localparam logic [1:0] RegAlpha = 2'd1;
  localparam logic [1:0] RegHop   = 2'd2;

  // One interpolation request handed from the front to the back.
  typedef struct packed {
    logic signed [SmpW-1:0] prev;
    logic signed [SmpW-1:0] cur;
    logic [15:0]            frac;
    logic                   last;
  } reee_cmd_t;

endpackage

/* rtl/core/reee_front.sv */
// Front part: holds the previous sample and read position and issues one
// interpolation request per output. Depends on reee_pkg.
module reee_front
  import reee_pkg::*;
#(
  parameter int unsigned MaxUpsample = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [SmpW-1:0] sample_i,
  input  logic [StepW-1:0]       step_i,
  output logic                   cmd_valid_o,
  input  logic                   cmd_full_i,
  output reee_cmd_t              cmd_o
);

  localparam int unsigned MinStep = (65536 + MaxUpsample - 1) / MaxUpsample;
  localparam int unsigned CntW = $clog2(MaxUpsample + 1);

  logic signed [SmpW-1:0] prev_q, prev_d, cur_q, cur_d;
  logic                   have_q, have_d, busy_q, busy_d;
  logic [PosW-1:0]        pos_q, pos_d, pos_nx;
  logic [StepW-1:0]       st_q, st_d;
  logic [CntW-1:0]        n_q, n_d;
  logic                   more;

  assign in_stall = busy_q;
  assign pos_nx = pos_q + PosW'(st_q);
  assign more = (pos_nx < 32'h10000) && (n_q != CntW'(MaxUpsample - 1));
  assign cmd_valid_o = busy_q;
  assign cmd_o = '{prev: prev_q, cur: cur_q, frac: pos_q[15:0], last: !more};

  // Sequencing of the interpolations for one sample.
  always_comb begin
    prev_d = prev_q; cur_d = cur_q; have_d = have_q; busy_d = busy_q;
    pos_d = pos_q; st_d = st_q; n_d = n_q;
    if (!busy_q && in_valid) begin
      if (!have_q || step_i == '0) begin
        prev_d = sample_i;
        have_d = 1'b1;
      end else begin
        cur_d = sample_i;
        st_d = (step_i < StepW'(MinStep)) ? StepW'(MinStep) : step_i;
        n_d = '0;
        if (pos_q < 32'h10000) begin
          busy_d = 1'b1;
        end else begin
          pos_d = pos_q - 32'h10000;
          prev_d = sample_i;
        end
      end
    end else if (busy_q && !cmd_full_i) begin
      pos_d = pos_nx;
      n_d = n_q + 1'b1;
      if (!more) begin
        busy_d = 1'b0;
        if (pos_nx >= 32'h10000) begin
          pos_d = pos_nx - 32'h10000;
          prev_d = cur_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0; have_q <= 1'b0; busy_q <= 1'b0; pos_q <= '0;
      st_q <= '0; n_q <= '0; cur_q <= '0;
    end else begin
      prev_q <= prev_d; have_q <= have_d; busy_q <= busy_d; pos_q <= pos_d;
      st_q <= st_d; n_q <= n_d; cur_q <= cur_d;
    end
  end

endmodule

/* rtl/core/reee_queue.sv */
// Short request queue between the front and the back parts.
// Depends on reee_pkg.
module reee_queue
  import reee_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_i,
  input  reee_cmd_t wdata_i,
  output logic      full_o,
  input  logic      rd_i,
  output logic      empty_o,
  output reee_cmd_t rdata_o
);

  reee_cmd_t  mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign rdata_o = mem_q[rp_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (wr_i && !full_o) mem_q[wp_q] <= wdata_i;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr_i && !full_o) wp_q <= ~wp_q;
      if (rd_i && !empty_o) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr_i && !full_o} - {1'b0, rd_i && !empty_o};
    end
  end

endmodule

/* rtl/core/reee_back.sv */
// Back part: blend, low-pass filter, energy sum and per-hop division and iterative root.
// Depends on reee_pkg.
module reee_back
  import reee_pkg::*;
#(
  parameter int unsigned MaxHop = 4096
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_empty_i,
  input  reee_cmd_t              cmd_i,
  output logic                   q_rd_o,
  input  logic [AlphaW-1:0]      alpha_i,
  input  logic [HopW-1:0]        hop_i,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [SmpW-1:0] resampled_sample_o,
  output logic                   energy_valid_o,
  output logic [EnW-1:0]         energy_value_o,
  output logic                   last_o
);

  localparam logic [2:0] SIdle = 3'd0, SBlend = 3'd1, SFilt = 3'd2, SSq = 3'd3,
                         SDiv = 3'd4, SSqrt = 3'd5, SOut = 3'd6;

  logic [2:0]             st_q, st_d;
  logic signed [LvlW-1:0] lvl_q, lvl_d;
  logic [SumW-1:0]        sum_q, sum_d;
  logic [HopW-1:0]        fill_q, fill_d;
  logic signed [SmpW-1:0] y_q, y_d;
  logic signed [34:0]     bl_q, bl_d;
  logic [SumW-1:0]        quo_q, quo_d, rem_q, rem_d;
  logic [6:0]             cnt_q, cnt_d;
  logic [47:0]            rv_q, rv_d;
  logic [23:0]            res_q, res_d;
  logic                   ev_q, ev_d, last_q, last_d, vld_q, vld_d;
  logic [EnW-1:0]         en_q, en_d;
  logic [HopW-1:0]        hop;
  logic signed [17:0]     wa, wb;
  logic signed [34:0]     pa, pb;
  logic signed [25:0]     diff;
  logic signed [42:0]     prod;
  logic signed [LvlW-1:0] inc;
  logic signed [35:0]     bl_rnd;
  logic [SumW:0]          trial;

  assign hop = (32'(hop_i) > MaxHop) ? HopW'(MaxHop) : hop_i;
  assign wa = 18'sd65536 - $signed({2'b0, cmd_i.frac});
  assign wb = $signed({2'b0, cmd_i.frac});
  assign pa = wa * cmd_i.prev;
  assign pb = wb * cmd_i.cur;
  assign bl_rnd = 36'(bl_q) + 36'sd32768;
  assign diff = $signed({{2{y_q[SmpW-1]}}, y_q, 8'b0}) - 26'(lvl_q);
  assign prod = $signed({1'b0, alpha_i}) * diff + 43'sd32768;
  assign inc = LvlW'(prod >>> 16);
  assign trial = {rem_q, quo_q[SumW-1]} - {{(SumW-HopW+1){1'b0}}, fill_q};

  assign q_rd_o = (st_q == SIdle) && !q_empty_i && !vld_q;
  assign out_valid = vld_q;
  assign resampled_sample_o = y_q;
  assign energy_valid_o = ev_q;
  assign energy_value_o = en_q;
  assign last_o = last_q;

  // Sequencer: one request through blend, optional filter, sum, division and root.
  always_comb begin
    logic [49:0] rem_sh;
    logic [49:0] tr;
    st_d = st_q; lvl_d = lvl_q; sum_d = sum_q; fill_d = fill_q; y_d = y_q;
    bl_d = bl_q; quo_d = quo_q; rem_d = rem_q; cnt_d = cnt_q; rv_d = rv_q;
    res_d = res_q; ev_d = ev_q; last_d = last_q; vld_d = vld_q; en_d = en_q;
    rem_sh = '0; tr = '0;
    if (vld_q && !out_stall) vld_d = 1'b0;
    case (st_q)
      SIdle: if (q_rd_o) begin
        bl_d = pa + pb;
        last_d = cmd_i.last;
        st_d = SBlend;
      end
      SBlend: begin
        y_d = SmpW'(bl_rnd >>> 16);
        ev_d = 1'b0; en_d = '0;
        st_d = (hop == '0) ? SOut : SFilt;
      end
      SFilt: begin
        lvl_d = lvl_q + inc;
        fill_d = fill_q + 1'b1;
        st_d = SSq;
      end
      SSq: begin
        sum_d = sum_q + SumW'(lvl_q * lvl_q);
        if (fill_q >= hop) begin
          quo_d = sum_q + SumW'(lvl_q * lvl_q);
          rem_d = '0; cnt_d = '0;
          if (fill_q == '0) fill_d = HopW'(1);
          st_d = SDiv;
        end else begin
          st_d = SOut;
        end
      end
      SDiv: begin
        // Restoring division, one quotient bit a cycle.
        if (!trial[SumW]) begin
          rem_d = trial[SumW-1:0];
          quo_d = {quo_q[SumW-2:0], 1'b1};
        end else begin
          rem_d = {rem_q[SumW-2:0], quo_q[SumW-1]};
          quo_d = {quo_q[SumW-2:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 7'd63) begin
          rv_d = quo_d[63:16];
          res_d = '0; rem_d = '0; cnt_d = '0;
          st_d = SSqrt;
        end
      end
      SSqrt: begin
        // Digit-by-digit root, two radicand bits a cycle.
        rem_sh = {rem_q[47:0], rv_q[47:46]};
        tr = rem_sh - {24'b0, res_q, 2'b01};
        rv_d = {rv_q[45:0], 2'b00};
        if (!tr[49]) begin
          rem_d = SumW'(tr);
          res_d = {res_q[22:0], 1'b1};
        end else begin
          rem_d = SumW'(rem_sh);
          res_d = {res_q[22:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 7'd23) begin
          en_d = (res_d > 24'd32767) ? EnW'(32767) : res_d[EnW-1:0];
          ev_d = 1'b1;
          sum_d = '0; fill_d = '0;
          st_d = SOut;
        end
      end
      SOut: if (!vld_q) begin
        vld_d = 1'b1;
        st_d = SIdle;
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; lvl_q <= '0; sum_q <= '0; fill_q <= '0; vld_q <= 1'b0;
    end else begin
      st_q <= st_d; lvl_q <= lvl_d; sum_q <= sum_d; fill_q <= fill_d; vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q <= y_d; bl_q <= bl_d; quo_q <= quo_d; rem_q <= rem_d; cnt_q <= cnt_d;
    rv_q <= rv_d; res_q <= res_d; ev_q <= ev_d; last_q <= last_d; en_q <= en_d;
  end

endmodule

/* rtl/core/resampler_energy_envelope_unit.sv */
// Linear-interpolation resampler with a smoothed energy envelope. Each input
// sample yields up to MaxUpsample output results; the front issues one
// request per cycle into a two-entry queue while the queue is not full, and
// the back takes each result through blend, filter, square-and-sum and output
// states (blend and output only when hop_length is zero), and adds a 64-step
// divider and a 24-step root on a result that closes a hop. The back holds a
// finished result until the output is not stalled before it takes the next.
// Configuration registers: step, alpha, hop_length.
// Depends on reee_pkg, reee_front, reee_queue, reee_back.
module resampler_energy_envelope_unit
  import reee_pkg::*;
#(
  parameter int unsigned MaxUpsample = 8,
  parameter int unsigned MaxHop      = 4096
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [StepW-1:0]       cfg_data_i,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [SmpW-1:0] sample_i,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [SmpW-1:0] resampled_sample_o,
  output logic                   energy_valid_o,
  output logic [EnW-1:0]         energy_value_o,
  output logic                   last_o
);

  logic [StepW-1:0]  step_q;
  logic [AlphaW-1:0] alpha_q;
  logic [HopW-1:0]   hop_q;
  logic              cmd_valid, q_full, q_empty, q_rd;
  reee_cmd_t         cmd_w, cmd_r;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepW'(131072); alpha_q <= AlphaW'(2686); hop_q <= HopW'(512);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegStep:  step_q <= cfg_data_i;
        RegAlpha: alpha_q <= cfg_data_i[AlphaW-1:0];
        RegHop:   hop_q <= cfg_data_i[HopW-1:0];
        default:  ;
      endcase
    end
  end

  reee_front #(.MaxUpsample(MaxUpsample)) u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall, .sample_i, .step_i(step_q),
    .cmd_valid_o(cmd_valid), .cmd_full_i(q_full), .cmd_o(cmd_w)
  );

  reee_queue u_queue (
    .clk_i, .rst_ni, .wr_i(cmd_valid), .wdata_i(cmd_w), .full_o(q_full),
    .rd_i(q_rd), .empty_o(q_empty), .rdata_o(cmd_r)
  );

  reee_back #(.MaxHop(MaxHop)) u_back (
    .clk_i, .rst_ni, .q_empty_i(q_empty), .cmd_i(cmd_r), .q_rd_o(q_rd),
    .alpha_i(alpha_q), .hop_i(hop_q), .out_valid, .out_stall,
    .resampled_sample_o, .energy_valid_o, .energy_value_o, .last_o
  );

endmodule

/* tb/resampler_energy_envelope_unit_tb.sv */
// Self-checking testbench for the resampler energy envelope unit.
// It predicts interpolated samples and hop energy values in a local model and
// compares them with the block outputs. Depends on reee_pkg and the RTL.
`timescale 1ns / 100ps

module resampler_energy_envelope_unit_tb;
  import reee_pkg::*;

  localparam int unsigned MaxUp  = 8;
  localparam int unsigned MaxHp  = 4096;
  localparam int unsigned OneQ16 = 65536;
  localparam int unsigned MinStp = (OneQ16 + MaxUp - 1) / MaxUp;
  localparam int unsigned DirN   = 20;

  typedef struct packed {
    logic signed [SmpW-1:0] smp;
    logic                   ev;
    logic [EnW-1:0]         en;
    logic                   lst;
  } blend_res_t;

  typedef struct {
    logic signed [SmpW-1:0] smp;
    bit                     known;
    blend_res_t             res;
  } dir_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [1:0]             cfg_idx_i;
  logic [StepW-1:0]       cfg_data_i;
  logic                   in_valid;
  logic                   in_stall;
  logic signed [SmpW-1:0] sample_i;
  logic                   out_valid;
  logic                   out_stall;
  logic signed [SmpW-1:0] resampled_sample_o;
  logic                   energy_valid_o;
  logic [EnW-1:0]         energy_value_o;
  logic                   last_o;

  // Predictor state and configuration copy.
  logic [StepW-1:0]       m_step;
  logic [AlphaW-1:0]      m_alpha;
  logic [HopW-1:0]        m_hop;
  logic signed [SmpW-1:0] m_prev;
  bit                     m_have;
  logic [PosW-1:0]        m_pos;
  logic signed [LvlW-1:0] m_lvl;
  logic [SumW-1:0]        m_sum;
  logic [HopW-1:0]        m_fill;

  blend_res_t exp_q[$];
  dir_row_t   dir_tab[DirN];
  int         n_err;
  int         n_res;
  int         n_energy;
  int         in_idle_pct;
  int         out_idle_pct;

  resampler_energy_envelope_unit u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .sample_i           (sample_i),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .resampled_sample_o (resampled_sample_o),
    .energy_valid_o     (energy_valid_o),
    .energy_value_o     (energy_value_o),
    .last_o             (last_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Overall time limit.
  initial begin
    #20000000;
    $display("FAILED: results differ");
    $finish;
  end

  // Round half up of x / 2^16.
  function automatic longint rnd_q16(longint x);
    return (x + 32768) >>> 16;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Works out the results caused by one accepted sample.
  task automatic predict_blends(logic signed [SmpW-1:0] cur);
    int unsigned st;
    int unsigned hp;
    int          n;
    longint      f;
    longint      y;
    longint      dif;
    longint      lv;
    longint unsigned cnt;
    longint unsigned r;
    blend_res_t  e;
    st = 32'(m_step);
    hp = (32'(m_hop) > MaxHp) ? MaxHp : 32'(m_hop);
    n = 0;
    if (!m_have || st == 0) begin
      m_prev = cur;
      m_have = 1'b1;
      return;
    end
    if (st < MinStp) st = MinStp;
    while (m_pos < OneQ16 && n < MaxUp) begin
      f = longint'(m_pos);
      y = rnd_q16((OneQ16 - f) * longint'(m_prev) + f * longint'(cur));
      e = '0;
      e.smp = y[SmpW-1:0];
      if (hp != 0) begin
        dif = y * 256 - longint'(m_lvl);
        lv = longint'(m_lvl) + rnd_q16(longint'(m_alpha) * dif);
        m_lvl = lv[LvlW-1:0];
        m_sum += longint'(m_lvl) * longint'(m_lvl);
        m_fill = m_fill + 1'b1;
        if (32'(m_fill) >= hp) begin
          cnt = (m_fill != '0) ? 64'(m_fill) : 64'd1;
          r = int_sqrt((m_sum / cnt) >> 16);
          e.en = (r > 32767) ? 15'h7fff : r[EnW-1:0];
          e.ev = 1'b1;
          m_sum = '0;
          m_fill = '0;
        end
      end
      exp_q.insert(exp_q.size(), e);
      n++;
      m_pos += st;
    end
    if (n > 0) exp_q[$].lst = 1'b1;
    if (m_pos >= OneQ16) begin
      m_pos -= OneQ16;
      m_prev = cur;
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [StepW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      RegStep:  m_step  = val;
      RegAlpha: m_alpha = val[AlphaW-1:0];
      RegHop:   m_hop   = val[HopW-1:0];
      default:  ;
    endcase
  endtask

  // Waits for all results, then for a hop-closing latency before reconfiguring.
  task automatic drain_results();
    while (exp_q.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  // Sends one sample request and waits for its acceptance.
  task automatic send_sample(logic signed [SmpW-1:0] s, bit idle_ok);
    if (idle_ok) begin
      while ($urandom_range(99) < in_idle_pct) begin
        in_valid = 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid = 1'b1;
    sample_i = s;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    predict_blends(s);
    @(negedge clk_i);
    in_valid = 1'b0;
  endtask

  // Random sample: mostly smooth audio, with extremes and noise mixed in.
  function automatic logic signed [SmpW-1:0] rand_sample(logic signed [SmpW-1:0] last_s);
    int unsigned k;
    k = $urandom_range(9);
    if (k == 0) return ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
    if (k < 3) return 16'($urandom);
    return last_s + $signed(16'($urandom_range(4000))) - 16'sd2000;
  endfunction

  // Output side: random stall and comparison with the oldest expectation.
  always @(negedge clk_i) begin
    if (rst_ni) out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  always @(posedge clk_i) begin
    blend_res_t got;
    blend_res_t want;
    if (rst_ni && out_valid && !out_stall) begin
      got = {resampled_sample_o, energy_valid_o, energy_value_o, last_o};
      n_res++;
      if (energy_valid_o) n_energy++;
      if (exp_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("Unexpected result %h", got);
      end else begin
        want = exp_q.pop_front();
        if (got !== want) begin
          n_err++;
          if (n_err <= 10)
            $display({"Mismatch: exp smp=%0d ev=%0b en=%0d last=%0b, ",
                      "got smp=%0d ev=%0b en=%0d last=%0b"},
                     want.smp, want.ev, want.en, want.lst,
                     got.smp, got.ev, got.en, got.lst);
        end
      end
    end
  end

  initial begin
    logic signed [SmpW-1:0] s;
    logic [StepW-1:0] steps [6];
    logic [HopW-1:0]  hops [6];
    int               ph;
    int               i;
    steps = '{23'd131072, 23'd65536, 23'd1, 23'd20000, 23'd4194304, 23'd0};
    hops  = '{13'd512, 13'd1, 13'd0, 13'd8191, 13'd7, 13'd3};
    n_err = 0; n_res = 0; n_energy = 0;
    in_idle_pct = 0; out_idle_pct = 0;
    cfg_we_i = 1'b0; cfg_idx_i = RegStep; cfg_data_i = '0;
    in_valid = 1'b0; sample_i = '0; out_stall = 1'b0;
    m_step = 23'd131072; m_alpha = 16'd2686; m_hop = 13'd512;
    m_prev = '0; m_have = 1'b0; m_pos = '0; m_lvl = '0; m_sum = '0; m_fill = '0;
    rst_ni = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table: extremes with full-scale step one and hop one.
    write_reg(RegStep, 23'd65536);
    write_reg(RegAlpha, 16'hffff);
    write_reg(RegHop, 13'd1);
    dir_tab[0] = '{16'sh7fff, 1'b0, '0};
    dir_tab[1] = '{16'sh8000, 1'b1, '{16'sh7fff, 1'b1, 15'd32766, 1'b1}};
    for (i = 2; i < DirN; i++) begin
      dir_tab[i].smp = (i % 3 == 0) ? 16'sh7fff : (i % 3 == 1) ? 16'sh8000 : 16'sd0;
      dir_tab[i].known = 1'b0;
    end
    for (i = 0; i < DirN; i++) begin
      if (dir_tab[i].known) begin
        send_sample(dir_tab[i].smp, 1'b0);
        if (exp_q.size() != 1 || exp_q[0] !== dir_tab[i].res) begin
          n_err++;
          $display("Directed row %0d predicts an unexpected result", i);
        end
      end else begin
        send_sample(dir_tab[i].smp, 1'b0);
      end
      if (i == 8) begin
        drain_results();
        write_reg(RegStep, 23'd1);
        write_reg(RegHop, 13'd8191);
      end
      if (i == 14) begin
        drain_results();
        write_reg(RegStep, 23'd0);
        write_reg(RegHop, 13'd0);
      end
    end
    drain_results();

    // Random phases over several settings and idling patterns.
    s = '0;
    for (ph = 0; ph < 12; ph++) begin
      case (ph % 3)
        0: begin in_idle_pct = 26; out_idle_pct = 48; end
        1: begin in_idle_pct = 48; out_idle_pct = 26; end
        default: begin in_idle_pct = 0; out_idle_pct = 0; end
      endcase
      if (ph >= 9) begin in_idle_pct = 0; out_idle_pct = 0; end
      write_reg(RegStep, (ph < 6) ? steps[ph] : 23'($urandom_range(200000)));
      write_reg(RegAlpha, (ph == 4) ? 16'd0 : 16'($urandom));
      write_reg(RegHop, (ph < 6) ? hops[ph] : 13'($urandom_range(40)));
      for (i = 0; i < 42; i++) begin
        s = rand_sample(s);
        send_sample(s, 1'b1);
      end
      drain_results();
    end
    out_idle_pct = 0;
    drain_results();

    $display("Run covered %0d results, %0d of them hop energy values, over 12 settings.",
             n_res, n_energy);
    if (n_err == 0 && exp_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/reee_pkg.sv
rtl/core/reee_front.sv
rtl/core/reee_queue.sv
rtl/core/reee_back.sv
rtl/core/resampler_energy_envelope_unit.sv
tb/resampler_energy_envelope_unit_tb.sv
